>>> src/tcpt_pkg.sv
// Shared types and constants for the tool calibration progress tracker.
// No dependencies; every other source file imports this package.
`default_nettype none

package tcpt_pkg;

    // Tool slots held by the tracker
    localparam int MAX_TOOLS  = 16;

    // Field widths fixed by the item format
    localparam int FUNC_W     = 3;
    localparam int TOOL_W     = 6;
    localparam int TOOL_MAG_W = TOOL_W - 1;
    localparam int STATUS_W   = 3;
    localparam int MIDX_W     = 4;
    localparam int CFG_W      = 5;

    // Derived widths
    localparam int CNT_W      = $clog2(MAX_TOOLS + 1);
    localparam int IDX_W      = (MAX_TOOLS > 1) ? $clog2(MAX_TOOLS) : 1;
    localparam int CMP_W      = (CNT_W > TOOL_W) ? CNT_W : TOOL_W;

    // Configuration port
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_BEGIN    = 3'd0,
        FN_FINISH   = 3'd1,
        FN_ABORT    = 3'd2,
        FN_SELECT   = 3'd3,
        FN_MEASURED = 3'd4,
        FN_QUERY    = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE      = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_MEASURING = 3'd2,
        ST_DONE      = 3'd3,
        ST_FAILED    = 3'd4
    } t_tool_st;

endpackage

`default_nettype wire

>>> src/tcpt_if.sv
// Valid/ready channel interfaces for event items and result items.
// Depends on tcpt_pkg for field widths.
`default_nettype none

interface tcpt_in_if import tcpt_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic signed [TOOL_W-1:0] tool;
    logic                  ok;

    modport source (output valid, output func, output tool, output ok, input ready);
    modport sink   (input valid, input func, input tool, input ok, output ready);
endinterface

interface tcpt_out_if import tcpt_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  active;
    logic                  failed;
    logic                  measuring_valid;
    logic [MIDX_W-1:0]     meas_slot;
    logic [STATUS_W-1:0]   tool_status;

    modport source (output valid, output active, output failed, output measuring_valid,
                    output meas_slot, output tool_status, input ready);
    modport sink   (input valid, input active, input failed, input measuring_valid,
                    input meas_slot, input tool_status, output ready);
endinterface

`default_nettype wire

>>> src/tool_calibration_progress_tracker.sv
// An item is registered on entry in the input register, then evaluated and its result
// registered in the result register, which presents it. A stalled result holds the input
// once its register is full. Throughput: one item per cycle while the result is not stalled;
// the per-tool status flops update in parallel in one pass.
// Reset (i_rst_n low, synchronous): all tools idle, run count zero, run flags clear,
// slot limit zero, both pipeline registers empty.
// Depends on tcpt_pkg and the channel interfaces in tcpt_if.sv.
`default_nettype none

module tool_calibration_progress_tracker import tcpt_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tcpt_in_if.sink                 in_ch,
    tcpt_out_if.source              out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------
    // Configuration register. Only one register exists, so every write
    // lands on the slot limit regardless of the byte offset.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_slot_limit;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = PDATA_W'(r_slot_limit);

    // paddr carries no decode: the register file has a single word
    logic unused_paddr;
    assign unused_paddr = ^paddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= '0;
        end else if (cfg_wr && !unused_paddr | cfg_wr) begin
            r_slot_limit <= pwdata[CFG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The evaluation stage advances when the result register
    // is empty or being drained; the input register refills behind it.
    // ------------------------------------------------------------------
    logic                      r_in_valid;
    logic [FUNC_W-1:0]         r_in_func;
    logic signed [TOOL_W-1:0]  r_in_tool;
    logic                      r_in_ok;

    logic                      r_out_valid;
    logic                      r_out_active;
    logic                      r_out_failed;
    logic                      r_out_mvalid;
    logic [MIDX_W-1:0]         r_out_midx;
    logic [STATUS_W-1:0]       r_out_status;

    logic stage_en;
    logic fire;

    assign stage_en    = !r_out_valid || out_ch.ready;
    assign fire        = r_in_valid && stage_en;
    assign in_ch.ready = !r_in_valid || stage_en;

    // ------------------------------------------------------------------
    // Tracker state
    // ------------------------------------------------------------------
    t_tool_st         r_tool_st [MAX_TOOLS];
    logic [CNT_W-1:0] r_run_count;
    logic             r_run_active;
    logic             r_run_failed;

    t_tool_st         n_tool_st [MAX_TOOLS];
    logic [CNT_W-1:0] n_run_count;
    logic             n_run_active;
    logic             n_run_failed;

    // Tool decode: negative tools never address a slot
    logic                  tool_nonneg;
    logic [TOOL_MAG_W-1:0] tool_mag;
    logic [IDX_W-1:0]      tool_idx;
    logic                  in_run_cur;
    logic                  in_run_new;
    logic [CNT_W-1:0]      begin_count;
    t_func                 func;

    assign func        = t_func'(r_in_func);
    assign tool_nonneg = !r_in_tool[TOOL_W-1];
    assign tool_mag    = r_in_tool[TOOL_MAG_W-1:0];
    assign tool_idx    = IDX_W'(tool_mag);

    // Begin clamps the configured count to the slot count
    assign begin_count = (CMP_W'(r_slot_limit) < CMP_W'(MAX_TOOLS)) ?
                         CNT_W'(r_slot_limit) : CNT_W'(MAX_TOOLS);
    assign n_run_count = (func == FN_BEGIN) ? begin_count : r_run_count;

    assign in_run_cur  = tool_nonneg && (CMP_W'(tool_mag) < CMP_W'(r_run_count));
    assign in_run_new  = tool_nonneg && (CMP_W'(tool_mag) < CMP_W'(n_run_count));

    // Next state for one event; selection after begin sees the fresh run
    always_comb begin
        for (int i = 0; i < MAX_TOOLS; i++) begin
            n_tool_st[i] = r_tool_st[i];
        end
        n_run_active = r_run_active;
        n_run_failed = r_run_failed;

        case (func)
            FN_BEGIN: begin
                for (int i = 0; i < MAX_TOOLS; i++) begin
                    n_tool_st[i] = (CMP_W'(i) < CMP_W'(begin_count)) ? ST_QUEUED : ST_IDLE;
                end
                n_run_active = (begin_count != '0);
                n_run_failed = 1'b0;
            end
            FN_FINISH: begin
                if (r_run_active) begin
                    for (int i = 0; i < MAX_TOOLS; i++) begin
                        if (CMP_W'(i) < CMP_W'(r_run_count)) begin
                            if (r_tool_st[i] == ST_MEASURING) begin
                                n_tool_st[i] = r_in_ok ? ST_DONE : ST_FAILED;
                            end else if (r_tool_st[i] == ST_QUEUED) begin
                                n_tool_st[i] = r_in_ok ? ST_DONE : ST_IDLE;
                            end
                        end
                    end
                    n_run_failed = !r_in_ok;
                    n_run_active = 1'b0;
                end
            end
            FN_ABORT: begin
                if (r_run_active) begin
                    for (int i = 0; i < MAX_TOOLS; i++) begin
                        if ((CMP_W'(i) < CMP_W'(r_run_count)) &&
                            (r_tool_st[i] == ST_MEASURING || r_tool_st[i] == ST_QUEUED)) begin
                            n_tool_st[i] = ST_IDLE;
                        end
                    end
                    n_run_failed = 1'b0;
                    n_run_active = 1'b0;
                end
            end
            FN_MEASURED: begin
                if (r_run_active && in_run_cur) begin
                    n_tool_st[tool_idx] = ST_DONE;
                end
            end
            default: begin
                // select is handled below; query and unused codes hold state
            end
        endcase

        // Tool selection: retire whatever is measuring, start the new tool
        if ((func == FN_BEGIN || func == FN_SELECT) && n_run_active && in_run_new &&
            n_tool_st[tool_idx] != ST_DONE) begin
            for (int i = 0; i < MAX_TOOLS; i++) begin
                if ((CMP_W'(i) < CMP_W'(n_run_count)) && n_tool_st[i] == ST_MEASURING) begin
                    n_tool_st[i] = ST_DONE;
                end
            end
            n_tool_st[tool_idx] = ST_MEASURING;
        end
    end

    // Lowest measuring slot: scan from the top so the lowest hit wins
    logic              n_mvalid;
    logic [MIDX_W-1:0] n_midx;
    t_tool_st          n_status;

    always_comb begin
        n_mvalid = 1'b0;
        n_midx   = '0;
        for (int i = MAX_TOOLS - 1; i >= 0; i--) begin
            if ((CMP_W'(i) < CMP_W'(n_run_count)) && n_tool_st[i] == ST_MEASURING) begin
                n_mvalid = 1'b1;
                n_midx   = MIDX_W'(i);
            end
        end
        n_status = in_run_new ? n_tool_st[tool_idx] : ST_IDLE;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_run_count  <= '0;
            r_run_active <= 1'b0;
            r_run_failed <= 1'b0;
            for (int i = 0; i < MAX_TOOLS; i++) begin
                r_tool_st[i] <= ST_IDLE;
            end
        end else begin
            if (in_ch.ready) begin
                r_in_valid <= in_ch.valid;
            end
            if (stage_en) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_run_count  <= n_run_count;
                r_run_active <= n_run_active;
                r_run_failed <= n_run_failed;
                for (int i = 0; i < MAX_TOOLS; i++) begin
                    r_tool_st[i] <= n_tool_st[i];
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) begin
            r_in_func <= in_ch.func;
            r_in_tool <= in_ch.tool;
            r_in_ok   <= in_ch.ok;
        end
        if (fire) begin
            r_out_active <= n_run_active;
            r_out_failed <= n_run_failed;
            r_out_mvalid <= n_mvalid;
            r_out_midx   <= n_midx;
            r_out_status <= n_status;
        end
    end

    assign out_ch.valid           = r_out_valid;
    assign out_ch.active          = r_out_active;
    assign out_ch.failed          = r_out_failed;
    assign out_ch.measuring_valid = r_out_mvalid;
    assign out_ch.meas_slot       = r_out_midx;
    assign out_ch.tool_status     = r_out_status;

endmodule

`default_nettype wire

>>> src/tcpt_checker.sv
// Port-level checks for the tool calibration progress tracker, bound to the top level.
// Depends on tcpt_pkg and on the top level's ports.
`default_nettype none

module tcpt_checker import tcpt_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic                i_active,
    input wire logic                i_failed,
    input wire logic                i_measuring_valid,
    input wire logic [MIDX_W-1:0]   i_meas_slot,
    input wire logic [STATUS_W-1:0] i_tool_status
);

    // A stalled result item holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_active, i_failed, i_measuring_valid, i_meas_slot, i_tool_status}))
        else $error("result item changed while stalled");

    // Measuring only happens inside an active run
    a_meas_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_measuring_valid |-> i_active)
        else $error("measuring tool reported outside an active run");

    // No measuring tool means index zero
    a_meas_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_measuring_valid |-> i_meas_slot == '0)
        else $error("measuring index nonzero with no tool measuring");

    // A tool reported as measuring implies the measuring flag
    a_status_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_tool_status == ST_MEASURING |-> i_measuring_valid)
        else $error("tool measuring but measuring flag clear");

    // An active run cannot also be flagged as failed
    a_active_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_active |-> !i_failed)
        else $error("active run flagged failed");

endmodule

bind tool_calibration_progress_tracker tcpt_checker u_tcpt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (out_ch.valid),
    .i_out_ready       (out_ch.ready),
    .i_active          (out_ch.active),
    .i_failed          (out_ch.failed),
    .i_measuring_valid (out_ch.measuring_valid),
    .i_meas_slot       (out_ch.meas_slot),
    .i_tool_status     (out_ch.tool_status)
);

`default_nettype wire

>>> tb/tb_tool_calibration_progress_tracker.sv
// Self-checking testbench for tool_calibration_progress_tracker: directed events, then
// randomized calibration runs under several idle/stall mixes and slot limit settings.
// Depends on tcpt_pkg and the channel interfaces in tcpt_if.sv.

module tb_tool_calibration_progress_tracker;
    import tcpt_pkg::*;

    localparam int REG_SLOT_LIMIT = 0;       // register index of the slot limit
    localparam int CYCLE_LIMIT    = 400000;  // hard stop for a hung run
    localparam int HOLD_CYCLES    = 300;     // long receiver hold-off
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int MAX_PRINTS     = 50;

    // Event codes outside the defined set; both act as a query
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

    // One event item as queued for the driver
    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [TOOL_W-1:0] tool;
        logic                     ok;
    } tracker_event_t;

    // One result item as predicted for the monitor
    typedef struct packed {
        logic              active;
        logic              failed;
        logic              mvalid;
        logic [MIDX_W-1:0] midx;
        t_tool_st          status;
    } tracker_result_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tcpt_in_if  in_ch();
    tcpt_out_if out_ch();

    tool_calibration_progress_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the tracker state, advanced on every accepted item
    // ------------------------------------------------------------------
    t_tool_st           slot_st [MAX_TOOLS];
    logic [CNT_W-1:0]   run_len;
    logic               run_on;
    logic               run_bad;
    logic [CFG_W-1:0]   shadow_slot_limit;

    tracker_event_t     event_queue[$];      // items waiting for the driver
    tracker_result_t    expected_status[$];  // predicted results, oldest first

    int items_queued;
    int results_seen;
    int n_errors;
    int func_seen [8];
    int src_idle_pct;
    int snk_stall_pct;
    int cycles;
    logic hold_go;
    logic rx_hold;

    function automatic bit in_run(input int t);
        return t >= 0 && t < int'(run_len);
    endfunction

    // Selecting a tool closes any measuring one (as done) and starts the new one.
    // Done tools and tools outside the run are left alone.
    function automatic void select_slot(input int t);
        if (!run_on || !in_run(t))
            return;
        if (slot_st[t] == ST_DONE)
            return;
        for (int i = 0; i < int'(run_len); i++)
            if (slot_st[i] == ST_MEASURING)
                slot_st[i] = ST_DONE;
        slot_st[t] = ST_MEASURING;
    endfunction

    // Apply one event to the shadow state and return the result it must produce
    function automatic tracker_result_t apply_event(input logic [FUNC_W-1:0] f,
                                                    input logic signed [TOOL_W-1:0] tool,
                                                    input logic ok);
        tracker_result_t r;
        int t;
        t = tool;
        func_seen[f]++;
        case (f)
            FN_BEGIN: begin
                // a slot limit above the slot count is clamped
                run_len = (shadow_slot_limit > MAX_TOOLS) ? CNT_W'(MAX_TOOLS)
                                                          : shadow_slot_limit;
                for (int i = 0; i < MAX_TOOLS; i++)
                    slot_st[i] = (i < int'(run_len)) ? ST_QUEUED : ST_IDLE;
                run_on  = (run_len != 0);
                run_bad = 1'b0;
                select_slot(t);
            end
            FN_FINISH: begin
                if (run_on) begin
                    for (int i = 0; i < int'(run_len); i++) begin
                        if (slot_st[i] == ST_MEASURING)
                            slot_st[i] = ok ? ST_DONE : ST_FAILED;
                        else if (slot_st[i] == ST_QUEUED)
                            slot_st[i] = ok ? ST_DONE : ST_IDLE;
                    end
                    run_bad = !ok;
                    run_on  = 1'b0;
                end
            end
            FN_ABORT: begin
                if (run_on) begin
                    for (int i = 0; i < int'(run_len); i++)
                        if (slot_st[i] == ST_MEASURING || slot_st[i] == ST_QUEUED)
                            slot_st[i] = ST_IDLE;
                    run_bad = 1'b0;
                    run_on  = 1'b0;
                end
            end
            FN_SELECT: select_slot(t);
            FN_MEASURED: begin
                if (run_on && in_run(t))
                    slot_st[t] = ST_DONE;
            end
            default: ;  // query and the two unused codes leave the state alone
        endcase

        r.active = run_on;
        r.failed = run_bad;
        r.mvalid = 1'b0;
        r.midx   = '0;
        for (int i = 0; i < int'(run_len); i++) begin
            if (slot_st[i] == ST_MEASURING && !r.mvalid) begin
                r.mvalid = 1'b1;
                r.midx   = MIDX_W'(i);
            end
        end
        // tools outside the current run always read idle
        r.status = in_run(t) ? slot_st[t] : ST_IDLE;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTS)
            $display("[%0d] MISMATCH: %s", cycles, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d results seen",
                     cycles, results_seen, items_queued);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: keeps valid up until the item is taken, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        tracker_event_t ev;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_status.push_back(apply_event(in_ch.func, in_ch.tool, in_ch.ok));
            // slot is free when nothing is offered or the offer was just taken
            if (!in_ch.valid || in_ch.ready) begin
                if (event_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    ev = event_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.func  <= ev.func;
                    in_ch.tool  <= ev.tool;
                    in_ch.ok    <= ev.ok;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        tracker_result_t exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_status.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    exp_r = expected_status.pop_front();
                    if (out_ch.active !== exp_r.active)
                        report_mismatch($sformatf("active got %b exp %b",
                                                  out_ch.active, exp_r.active));
                    if (out_ch.failed !== exp_r.failed)
                        report_mismatch($sformatf("failed got %b exp %b",
                                                  out_ch.failed, exp_r.failed));
                    if (out_ch.measuring_valid !== exp_r.mvalid)
                        report_mismatch($sformatf("measuring_valid got %b exp %b",
                                                  out_ch.measuring_valid, exp_r.mvalid));
                    if (out_ch.meas_slot !== exp_r.midx)
                        report_mismatch($sformatf("meas_slot got %0d exp %0d",
                                                  out_ch.meas_slot, exp_r.midx));
                    if (out_ch.tool_status !== exp_r.status)
                        report_mismatch($sformatf("tool_status got %0d exp %0d",
                                                  out_ch.tool_status, exp_r.status));
                end
            end
            out_ch.ready <= !rx_hold && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Long receiver hold-off, timed in its own process; the input side backs up
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic [FUNC_W-1:0] f, input int t, input logic ok);
        tracker_event_t ev;
        ev.func = f;
        ev.tool = TOOL_W'(t);
        ev.ok   = ok;
        event_queue.push_back(ev);
        items_queued++;
    endtask

    // Mostly tools inside the run, some "none", some anywhere in the field's range
    function automatic int pick_tool(input int rc);
        int roll;
        roll = $urandom_range(99);
        if (rc > 0 && roll < 80)
            return $urandom_range(rc - 1);
        if (roll < 88)
            return -1;
        return int'($urandom_range(63)) - 32;
    endfunction

    // Random calibration runs: begin, one to eight tool events, then finish, abort or neither.
    // About one draw in five is a single unstructured noise item instead of a run.
    task automatic queue_runs(input int n, input int tc);
        int rc;
        int stop_at;
        int roll;
        rc = (tc > MAX_TOOLS) ? MAX_TOOLS : tc;
        stop_at = items_queued + n;
        while (items_queued < stop_at) begin
            if ($urandom_range(99) < 80) begin
                add_item(FN_BEGIN, pick_tool(rc), 1'($urandom));
                repeat ($urandom_range(1, 8)) begin
                    roll = $urandom_range(9);
                    if (roll < 5)
                        add_item(FN_SELECT, pick_tool(rc), 1'($urandom));
                    else if (roll < 7)
                        add_item(FN_MEASURED, pick_tool(rc), 1'($urandom));
                    else if (roll < 9)
                        add_item(FN_QUERY, pick_tool(rc), 1'($urandom));
                    else
                        add_item(FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)),
                                 pick_tool(rc), 1'($urandom));
                end
                roll = $urandom_range(99);
                if (roll < 60)
                    add_item(FN_FINISH, pick_tool(rc), 1'($urandom));
                else if (roll < 85)
                    add_item(FN_ABORT, pick_tool(rc), 1'($urandom));
            end else begin
                add_item(FUNC_W'($urandom_range(7)), int'($urandom_range(63)) - 32,
                         1'($urandom));
            end
        end
    endtask

    // APB write: setup cycle, then access cycle; the register takes it at the access edge
    task automatic write_slot_limit(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_SLOT_LIMIT);
        pwdata  <= {(PDATA_W-CFG_W)'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_slot_limit = v;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int phase_tc   [N_PHASES] = '{16, 0, 1, 31, 7, 17, 0, 16};
    int phase_src  [N_PHASES] = '{0, 63, 0, 18, 0, 63, 0, 18};
    int phase_snk  [N_PHASES] = '{0, 0, 63, 18, 0, 0, 63, 18};

    initial begin
        int tc;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.func        = '0;
        in_ch.tool        = '0;
        in_ch.ok          = 1'b0;
        out_ch.ready      = 1'b0;
        hold_go           = 1'b0;
        cycles            = 0;
        items_queued      = 0;
        results_seen      = 0;
        n_errors          = 0;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        shadow_slot_limit = '0;
        run_len           = '0;
        run_on            = 1'b0;
        run_bad           = 1'b0;
        foreach (slot_st[i]) slot_st[i] = ST_IDLE;
        foreach (func_seen[i]) func_seen[i] = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: events with no run open, then several runs at the widest setting
        add_item(FN_QUERY, 0, 1'b0);        // reset state
        add_item(FN_UNUSED_LO, 31, 1'b1);   // unused codes behave as a query
        add_item(FN_UNUSED_HI, -32, 1'b0);
        add_item(FN_FINISH, 0, 1'b1);       // no run: ignored
        add_item(FN_ABORT, 0, 1'b0);
        add_item(FN_SELECT, 0, 1'b0);
        add_item(FN_MEASURED, 0, 1'b1);
        add_item(FN_BEGIN, 0, 1'b0);        // slot limit still zero: no run
        wait_drained();
        write_slot_limit(CFG_W'(16));
        add_item(FN_BEGIN, -1, 1'b0);       // begin with no mounted tool
        add_item(FN_BEGIN, 0, 1'b1);        // mounted tool 0 starts measuring
        add_item(FN_SELECT, 15, 1'b0);      // 0 done, 15 measuring
        add_item(FN_SELECT, 0, 1'b0);       // already done: ignored
        add_item(FN_SELECT, -32, 1'b1);     // negative tool
        add_item(FN_SELECT, 31, 1'b0);      // beyond the slots
        add_item(FN_SELECT, 16, 1'b0);      // just past the run
        add_item(FN_MEASURED, 15, 1'b0);    // nothing measuring afterwards
        add_item(FN_SELECT, 3, 1'b1);
        add_item(FN_FINISH, 3, 1'b0);       // failure: measuring->failed, queued->idle
        add_item(FN_QUERY, 3, 1'b0);
        add_item(FN_QUERY, 31, 1'b1);
        add_item(FN_BEGIN, 5, 1'b1);
        add_item(FN_ABORT, 5, 1'b1);
        add_item(FN_BEGIN, 31, 1'b0);       // mounted tool out of range
        add_item(FN_MEASURED, 2, 1'b0);
        add_item(FN_FINISH, 2, 1'b1);       // success: queued tools become done
        wait_drained();

        // Random runs: one slot limit and one idle mix per phase
        for (int p = 0; p < N_PHASES; p++) begin
            tc = (p == 6) ? $urandom_range(31) : phase_tc[p];
            write_slot_limit(CFG_W'(tc));
            src_idle_pct  <= phase_src[p];
            snk_stall_pct <= phase_snk[p];
            if (p == 4)
                hold_go = 1'b1;     // receiver goes quiet while items keep coming
            queue_runs(PHASE_ITEMS, tc);
            wait_drained();
        end

        // Trailing cycles catch any extra result item
        repeat (10) @(posedge i_clk);

        $display("Covered %0d items in %0d phases (slot limit 0..31, one long receiver hold).",
                 items_queued, N_PHASES);
        $display("Events: %0d begin, %0d finish, %0d abort, %0d select, %0d measured, %0d query.",
                 func_seen[FN_BEGIN], func_seen[FN_FINISH], func_seen[FN_ABORT],
                 func_seen[FN_SELECT], func_seen[FN_MEASURED],
                 func_seen[FN_QUERY] + func_seen[FN_UNUSED_LO] + func_seen[FN_UNUSED_HI]);
        if (n_errors == 0 && expected_status.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d predictions left over", n_errors,
                     expected_status.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/tcpt_pkg.sv
src/tcpt_if.sv
src/tool_calibration_progress_tracker.sv
src/tcpt_checker.sv
tb/tb_tool_calibration_progress_tracker.sv
